### rtl/sastm_pkg.sv
// Shared types and constants of the agent sense, turn and move block.
package sastm_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_GRID_WIDTH   = 3'd0;
   localparam logic [2:0] REG_GRID_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_SPEED        = 3'd2;
   localparam logic [2:0] REG_SENSOR_RANGE = 3'd3;
   localparam logic [2:0] REG_SENSOR_SIZE  = 3'd4;
   localparam logic [2:0] REG_SENSOR_ANGLE = 3'd5;
   localparam logic [2:0] REG_TURN_ANGLE   = 3'd6;
   localparam logic [2:0] REG_EDGE_CLAMP   = 3'd7;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // sensor / heading select
   localparam logic [1:0] SEN_FWD = 2'd0;
   localparam logic [1:0] SEN_LFT = 2'd1;
   localparam logic [1:0] SEN_RGT = 2'd2;
   localparam logic [1:0] SEN_FIN = 2'd3;

   // quarter-wave sine polynomial, Q1.14
   localparam logic [14:0] QUARTER = 15'd16384;
   localparam logic [14:0] SIN_A   = 15'd25736;
   localparam logic [13:0] SIN_B   = 14'd10512;
   localparam logic [10:0] SIN_C   = 11'd1160;

   localparam int CRD_W = 20;   // sensor centre, whole cells, signed
   localparam int SUM_W = 13;   // window sum, 25 cells of 8 bits

   typedef struct packed {
      logic               opcode;
      logic [17:0]        cell_index;
      logic [7:0]         trail_value;
      logic [17:0]        agent_x;
      logic [17:0]        agent_y;
      logic [15:0]        agent_heading;
      logic signed [15:0] random_turn;
      logic [15:0]        random_heading;
   } sastm_req_type;

   typedef struct packed {
      logic [17:0] new_x;
      logic [17:0] new_y;
      logic [15:0] new_heading;
      logic        edge_hit;
   } sastm_rsp_type;

   typedef struct packed {
      logic              item_load;
      logic              mem_write;
      logic              trig_go;
      logic [1:0]        sensor;
      logic              ctr_mul;
      logic              ctr_add;
      logic              cell_go;
      logic signed [2:0] dx;
      logic signed [2:0] dy;
      logic              sum_store;
      logic              turn_mul;
      logic              turn_set;
      logic              move_mul;
      logic              move_add;
      logic              rsp_load;
   } sastm_cmd_type;

   typedef struct packed {
      logic trig_done;
      logic cells_busy;
   } sastm_stat_type;

endpackage

### rtl/sastm_dp.sv
// Datapath: trail memory, sine/cosine pipeline, sensor windows, turn and move.
module sastm_dp
   import sastm_pkg::*;
#(
   parameter int GRID_W_MAX    = 512,
   parameter int GRID_H_MAX    = 512,
   parameter int POS_FRAC_BITS = 8,
   parameter int GWW           = $clog2(GRID_W_MAX + 1),
   parameter int GHW           = $clog2(GRID_H_MAX + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  sastm_cmd_type cmd,
   output sastm_stat_type stat,
   input  sastm_req_type req_data,
   input  logic [GWW-1:0] grid_w,
   input  logic [GHW-1:0] grid_h,
   input  logic [9:0]    speed,
   input  logic [4:0]    probe_range,
   input  logic [1:0]    half,
   input  logic [15:0]   sensor_angle,
   input  logic [15:0]   turn_angle,
   input  logic          edge_clamp,
   output sastm_rsp_type rsp_data
);

   localparam int F     = POS_FRAC_BITS;
   localparam int GXW   = $clog2(GRID_W_MAX);
   localparam int GYW   = $clog2(GRID_H_MAX);
   localparam int DEPTH = GRID_W_MAX * GRID_H_MAX;
   localparam int AW    = $clog2(DEPTH);
   localparam int CVW   = 34 + F;
   localparam int MVW   = 28 + F;
   localparam int GMW   = (GWW > GHW) ? GWW : GHW;
   localparam int PSA   = GMW + F;
   localparam int PSW   = ((PSA > 19) ? PSA : 19) + 2;

   function automatic logic signed [CRD_W-1:0] fold_cell(
      input logic signed [CRD_W-1:0] c,
      input logic signed [CRD_W-1:0] n,
      input logic near,
      input logic clamp
   );
      logic signed [CRD_W-1:0] v;
      v = c;
      if (near) begin
         if (clamp) begin
            if (c < 0) v = '0;
            else if (c > n) v = n;
         end else begin
            if (c > n) v = c - n;
            else if (c < 0) v = c + n;
         end
      end
      if (v < 0) v = '0;
      else if (v > n - 1) v = n - 1;
      return v;
   endfunction

   function automatic logic signed [PSW-1:0] fold_pos(
      input logic signed [PSW-1:0] c,
      input logic signed [PSW-1:0] n,
      input logic hit,
      input logic clamp
   );
      logic signed [PSW-1:0] v;
      v = c;
      if (hit) begin
         if (clamp) begin
            if (c < 0) v = '0;
            else if (c > n) v = n;
         end else begin
            if (c > n) v = c - n;
            else if (c < 0) v = c + n;
         end
      end
      if (v < 0) v = '0;
      else if (v > n) v = n;
      return v;
   endfunction

   // item registers
   logic [17:0]        x_ff, y_ff;
   logic [15:0]        h_ff, rh_ff, hn_ff, hn_in;
   logic signed [15:0] rt_ff;

   // trail memory
   logic [7:0]    mem [DEPTH];
   logic [31:0]   widx;
   logic [AW-1:0] waddr;

   // trig pipeline, lane 0 sine, lane 1 cosine
   logic [15:0]        ang;
   logic [15:0]        a_l    [2];
   logic [14:0]        r0_in  [2];
   logic [29:0]        sq     [2];
   logic [25:0]        p2     [2];
   logic [28:0]        p3     [2];
   logic [29:0]        p4     [2];
   logic [15:0]        v4     [2];
   logic signed [15:0] trig_in[2];
   logic [14:0]        s0_r_ff [2], s1_r_ff [2], s2_r_ff [2], s3_r_ff [2];
   logic               s0_n_ff [2], s1_n_ff [2], s2_n_ff [2], s3_n_ff [2];
   logic [14:0]        s1_x2_ff[2], s2_x2_ff[2];
   logic [13:0]        s2_t_ff [2];
   logic [14:0]        s3_t_ff [2];
   logic signed [15:0] trig_ff [2];
   logic [3:0]         tv_ff;
   logic               tdone_ff;

   // sensor centre
   logic signed [21:0]      crx_ff, cry_ff;
   logic                    near_ff, near_in;
   logic [31:0]             reach32, x32, y32, wm1, hm1;
   logic signed [CVW-1:0]   cvx, cvy, csx, csy;
   logic signed [CRD_W-1:0] cx_ff, cy_ff;

   // cell pipeline
   logic signed [CRD_W-1:0] wS, hS, pxf, pyf;
   logic [GXW-1:0]          px_ff;
   logic [GYW-1:0]          py_ff;
   logic [GYW+GWW-1:0]      rowb;
   logic [AW-1:0]           addr_ff;
   logic [7:0]              rd_ff;
   logic                    vp_ff, va_ff, vm_ff;
   logic [SUM_W-1:0]        sum_ff, fwd_ff, lft_ff, rgt_ff;

   // turn and move
   logic signed [32:0]      tp_ff, tpsh;
   logic [15:0]             delta;
   logic signed [26:0]      mx_ff, my_ff;
   logic signed [MVW-1:0]   dvx, dvy, dsx, dsy;
   logic signed [PSW-1:0]   nx_ff, ny_ff, fullw, fullh, fx, fy;
   logic                    hit;

   // ---------------- item and memory ----------------
   assign widx  = 32'(req_data.cell_index);
   assign waddr = widx[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         x_ff  <= req_data.agent_x;
         y_ff  <= req_data.agent_y;
         h_ff  <= req_data.agent_heading;
         rt_ff <= req_data.random_turn;
         rh_ff <= req_data.random_heading;
      end
      // drop writes beyond the store
      if (cmd.mem_write && widx < 32'(DEPTH)) begin
         mem[waddr] <= req_data.trail_value;
      end
      rd_ff <= mem[addr_ff];
   end

   // ---------------- sine / cosine ----------------
   always_comb begin
      case (cmd.sensor)
         SEN_FWD: ang = h_ff;
         SEN_LFT: ang = h_ff + sensor_angle;
         SEN_RGT: ang = h_ff - sensor_angle;
         default: ang = hn_ff;
      endcase
      a_l[0] = ang;
      a_l[1] = ang + 16'(QUARTER);
      for (int i = 0; i < 2; i++) begin
         r0_in[i] = a_l[i][14] ? QUARTER - {1'b0, a_l[i][13:0]} : {1'b0, a_l[i][13:0]};
         sq[i]    = s0_r_ff[i] * s0_r_ff[i];
         p2[i]    = SIN_C * s1_x2_ff[i];
         p3[i]    = s2_t_ff[i] * s2_x2_ff[i];
         p4[i]    = s3_t_ff[i] * s3_r_ff[i];
         v4[i]    = (p4[i][29:14] > 16'(QUARTER)) ? 16'(QUARTER) : p4[i][29:14];
         trig_in[i] = s3_n_ff[i] ? -$signed(v4[i]) : $signed(v4[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         s0_r_ff[i]  <= r0_in[i];
         s0_n_ff[i]  <= a_l[i][15];
         s1_x2_ff[i] <= sq[i][28:14];
         s1_r_ff[i]  <= s0_r_ff[i];
         s1_n_ff[i]  <= s0_n_ff[i];
         s2_t_ff[i]  <= SIN_B - {3'b000, p2[i][24:14]};
         s2_x2_ff[i] <= s1_x2_ff[i];
         s2_r_ff[i]  <= s1_r_ff[i];
         s2_n_ff[i]  <= s1_n_ff[i];
         s3_t_ff[i]  <= SIN_A - p3[i][28:14];
         s3_r_ff[i]  <= s2_r_ff[i];
         s3_n_ff[i]  <= s2_n_ff[i];
         if (tv_ff[3]) begin
            trig_ff[i] <= trig_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff    <= '0;
         tdone_ff <= 1'b0;
      end else begin
         tv_ff    <= {tv_ff[2:0], cmd.trig_go};
         tdone_ff <= tv_ff[3];
      end
   end

   // ---------------- sensor centre ----------------
   always_comb begin
      reach32 = (32'(probe_range) + 32'(half)) << F;
      x32     = 32'(x_ff);
      y32     = 32'(y_ff);
      wm1     = (32'(grid_w) - 32'd1) << F;
      hm1     = (32'(grid_h) - 32'd1) << F;
      near_in = (x32 < reach32) || (x32 + reach32 > wm1) ||
                (y32 < reach32) || (y32 + reach32 > hm1);
      cvx = (CVW'($signed({1'b0, x_ff})) <<< 14) + (CVW'(crx_ff) <<< F) +
            (CVW'(1) <<< (13 + F));
      cvy = (CVW'($signed({1'b0, y_ff})) <<< 14) + (CVW'(cry_ff) <<< F) +
            (CVW'(1) <<< (13 + F));
      csx = cvx >>> (14 + F);
      csy = cvy >>> (14 + F);
   end

   always_ff @(posedge clock) begin
      if (cmd.ctr_mul) begin
         crx_ff  <= 22'(trig_ff[1] * $signed({1'b0, probe_range}));
         cry_ff  <= 22'(trig_ff[0] * $signed({1'b0, probe_range}));
         near_ff <= near_in;
      end
      if (cmd.ctr_add) begin
         cx_ff <= csx[CRD_W-1:0];
         cy_ff <= csy[CRD_W-1:0];
      end
   end

   // ---------------- window cells ----------------
   always_comb begin
      wS   = $signed(CRD_W'(grid_w));
      hS   = $signed(CRD_W'(grid_h));
      pxf  = fold_cell(cx_ff + CRD_W'(cmd.dx), wS, near_ff, edge_clamp);
      pyf  = fold_cell(cy_ff + CRD_W'(cmd.dy), hS, near_ff, edge_clamp);
      rowb = py_ff * grid_w;
   end

   always_ff @(posedge clock) begin
      px_ff   <= pxf[GXW-1:0];
      py_ff   <= pyf[GYW-1:0];
      addr_ff <= AW'(rowb) + AW'(px_ff);
      if (cmd.sum_store) begin
         case (cmd.sensor)
            SEN_FWD: fwd_ff <= sum_ff;
            SEN_LFT: lft_ff <= sum_ff;
            default: rgt_ff <= sum_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff  <= 1'b0;
         va_ff  <= 1'b0;
         vm_ff  <= 1'b0;
         sum_ff <= '0;
      end else begin
         vp_ff <= cmd.cell_go;
         va_ff <= vp_ff;
         vm_ff <= va_ff;
         if (cmd.ctr_add) begin
            sum_ff <= '0;
         end else if (vm_ff) begin
            sum_ff <= sum_ff + SUM_W'(rd_ff);
         end
      end
   end

   assign stat.trig_done  = tdone_ff;
   assign stat.cells_busy = vp_ff | va_ff | vm_ff;

   // ---------------- turn ----------------
   always_comb begin
      tpsh  = tp_ff >>> 15;
      delta = tpsh[15:0];
      hn_in = h_ff;
      if (fwd_ff >= lft_ff && fwd_ff >= rgt_ff) begin
         hn_in = h_ff;
      end else if (fwd_ff < lft_ff && fwd_ff < rgt_ff) begin
         hn_in = h_ff + delta;
      end else if (lft_ff > rgt_ff) begin
         hn_in = h_ff + turn_angle;
      end else if (lft_ff < rgt_ff) begin
         hn_in = h_ff - turn_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.turn_mul) begin
         tp_ff <= rt_ff * $signed({1'b0, turn_angle});
      end
      if (cmd.turn_set) begin
         hn_ff <= hn_in;
      end
   end

   // ---------------- move ----------------
   always_comb begin
      dvx   = (MVW'(mx_ff) <<< F) + (MVW'(1) <<< 21);
      dvy   = (MVW'(my_ff) <<< F) + (MVW'(1) <<< 21);
      dsx   = dvx >>> 22;
      dsy   = dvy >>> 22;
      fullw = $signed(PSW'(grid_w)) <<< F;
      fullh = $signed(PSW'(grid_h)) <<< F;
      hit   = (nx_ff < 0) || (nx_ff > fullw - ($signed(PSW'(1)) <<< F)) ||
              (ny_ff < 0) || (ny_ff > fullh - ($signed(PSW'(1)) <<< F));
      fx    = fold_pos(nx_ff, fullw, hit, edge_clamp);
      fy    = fold_pos(ny_ff, fullh, hit, edge_clamp);
   end

   always_ff @(posedge clock) begin
      if (cmd.move_mul) begin
         mx_ff <= $signed({1'b0, speed}) * trig_ff[1];
         my_ff <= $signed({1'b0, speed}) * trig_ff[0];
      end
      if (cmd.move_add) begin
         nx_ff <= PSW'($signed({1'b0, x_ff})) + PSW'(dsx);
         ny_ff <= PSW'($signed({1'b0, y_ff})) + PSW'(dsy);
      end
      if (cmd.rsp_load) begin
         rsp_data.new_x       <= fx[17:0];
         rsp_data.new_y       <= fy[17:0];
         rsp_data.new_heading <= (hit && edge_clamp) ? rh_ff : hn_ff;
         rsp_data.edge_hit    <= hit;
      end
   end

endmodule

### rtl/sastm_ctrl.sv
// Controller: sequences sensing, turning, moving and the result word.
module sastm_ctrl
   import sastm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_opcode,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  logic [1:0]     half,
   input  sastm_stat_type stat,
   output sastm_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_TGO      = 4'd1;
   localparam logic [3:0] S_TRIG     = 4'd2;
   localparam logic [3:0] S_CMUL     = 4'd3;
   localparam logic [3:0] S_CADD     = 4'd4;
   localparam logic [3:0] S_SCAN     = 4'd5;
   localparam logic [3:0] S_DRAIN    = 4'd6;
   localparam logic [3:0] S_TURN_MUL = 4'd7;
   localparam logic [3:0] S_TURN_SET = 4'd8;
   localparam logic [3:0] S_MMUL     = 4'd9;
   localparam logic [3:0] S_MADD     = 4'd10;
   localparam logic [3:0] S_OUT      = 4'd11;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        sensor_ff, sensor_in;
   logic signed [2:0] dx_ff, dx_in, dy_ff, dy_in, hs;
   logic              rsp_valid_ff, rsp_valid_in;

   assign hs = $signed({1'b0, half});

   always_comb begin
      cmd          = '0;
      cmd.sensor   = sensor_ff;
      cmd.dx       = dx_ff;
      cmd.dy       = dy_ff;
      req_ready    = 1'b0;
      state_in     = state_ff;
      sensor_in    = sensor_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.item_load = 1'b1;
               if (req_opcode == OP_WRITE) begin
                  cmd.mem_write = 1'b1;
               end else begin
                  sensor_in = SEN_FWD;
                  state_in  = S_TGO;
               end
            end
         end
         S_TGO: begin
            cmd.trig_go = 1'b1;
            state_in    = S_TRIG;
         end
         S_TRIG: begin
            if (stat.trig_done) begin
               state_in = (sensor_ff == SEN_FIN) ? S_MMUL : S_CMUL;
            end
         end
         S_CMUL: begin
            cmd.ctr_mul = 1'b1;
            state_in    = S_CADD;
         end
         S_CADD: begin
            cmd.ctr_add = 1'b1;
            dx_in       = -hs;
            dy_in       = -hs;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            cmd.cell_go = 1'b1;
            if (dy_ff == hs) begin
               dy_in = -hs;
               if (dx_ff == hs) begin
                  state_in = S_DRAIN;
               end else begin
                  dx_in = dx_ff + 3'sd1;
               end
            end else begin
               dy_in = dy_ff + 3'sd1;
            end
         end
         S_DRAIN: begin
            // hold until the last cell is summed
            if (!stat.cells_busy) begin
               cmd.sum_store = 1'b1;
               if (sensor_ff == SEN_RGT) begin
                  state_in = S_TURN_MUL;
               end else begin
                  sensor_in = sensor_ff + 2'd1;
                  state_in  = S_TGO;
               end
            end
         end
         S_TURN_MUL: begin
            cmd.turn_mul = 1'b1;
            state_in     = S_TURN_SET;
         end
         S_TURN_SET: begin
            cmd.turn_set = 1'b1;
            sensor_in    = SEN_FIN;
            state_in     = S_TGO;
         end
         S_MMUL: begin
            cmd.move_mul = 1'b1;
            state_in     = S_MADD;
         end
         S_MADD: begin
            cmd.move_add = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sensor_ff    <= SEN_FWD;
         dx_ff        <= '0;
         dy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sensor_ff    <= sensor_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_idle_cells_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !stat.cells_busy)
      else $error("cell pipeline busy while idle");
   a_idle_trig_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !stat.trig_done)
      else $error("trig result outside a wait");
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten");
   a_scan_after_centre: assert property (@(posedge clock) disable iff (reset)
      (cmd.cell_go && $past(state_ff) != S_SCAN) |-> $past(cmd.ctr_add))
      else $error("window scan without centre");
`endif

endmodule

### rtl/slime_agent_sense_turn_move.sv
// Top level: agent sense, turn and move over a trail grid, with config registers.
// A write word stores one trail cell. An update word senses three square windows of
// (2*h+1)^2 cells, h being the window half width, then turns and moves the agent; no
// new input is taken until the result word is loaded, which also waits for the result
// register to empty. The window reads go one cell per cycle through the single read
// port of the trail memory, and each sensor waits on the four-stage sine/cosine pipeline.
// The trail memory has no reset: cells read before they are written return unknown
// data. Configuration is taken at any cycle and must only change while the block is idle.
module slime_agent_sense_turn_move
   import sastm_pkg::*;
#(
   parameter int GRID_W_MAX    = 512,
   parameter int GRID_H_MAX    = 512,
   parameter int POS_FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sastm_req_type         req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sastm_rsp_type         rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int GWW = $clog2(GRID_W_MAX + 1);
   localparam int GHW = $clog2(GRID_H_MAX + 1);

   logic [9:0]  gw_ff, gh_ff, speed_ff;
   logic [4:0]  range_ff;
   logic [1:0]  size_ff, half;
   logic [15:0] sangle_ff, tangle_ff;
   logic        clamp_ff;
   logic [31:0] gw32, gh32, w32, h32;
   logic [GWW-1:0] grid_w;
   logic [GHW-1:0] grid_h;

   sastm_cmd_type  cmd;
   sastm_stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff     <= 10'd512;
         gh_ff     <= 10'd512;
         speed_ff  <= 10'd448;
         range_ff  <= 5'd9;
         size_ff   <= 2'd1;
         sangle_ff <= 16'd8192;
         tangle_ff <= 16'd8192;
         clamp_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_GRID_WIDTH:   gw_ff     <= csr_wdata[9:0];
            REG_GRID_HEIGHT:  gh_ff     <= csr_wdata[9:0];
            REG_SPEED:        speed_ff  <= csr_wdata[9:0];
            REG_SENSOR_RANGE: range_ff  <= csr_wdata[4:0];
            REG_SENSOR_SIZE:  size_ff   <= csr_wdata[1:0];
            REG_SENSOR_ANGLE: sangle_ff <= csr_wdata;
            REG_TURN_ANGLE:   tangle_ff <= csr_wdata;
            REG_EDGE_CLAMP:   clamp_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // limit grid size to 1..max and window half width to 2
   always_comb begin
      gw32 = 32'(gw_ff);
      gh32 = 32'(gh_ff);
      if (gw32 == 32'd0) w32 = 32'd1;
      else if (gw32 > 32'(GRID_W_MAX)) w32 = 32'(GRID_W_MAX);
      else w32 = gw32;
      if (gh32 == 32'd0) h32 = 32'd1;
      else if (gh32 > 32'(GRID_H_MAX)) h32 = 32'(GRID_H_MAX);
      else h32 = gh32;
      grid_w = w32[GWW-1:0];
      grid_h = h32[GHW-1:0];
      half   = (size_ff > 2'd2) ? 2'd2 : size_ff;
   end

   sastm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .half       (half),
      .stat       (stat),
      .cmd        (cmd)
   );

   sastm_dp #(
      .GRID_W_MAX    (GRID_W_MAX),
      .GRID_H_MAX    (GRID_H_MAX),
      .POS_FRAC_BITS (POS_FRAC_BITS),
      .GWW           (GWW),
      .GHW           (GHW)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_data     (req_data),
      .grid_w       (grid_w),
      .grid_h       (grid_h),
      .speed        (speed_ff),
      .probe_range  (range_ff),
      .half         (half),
      .sensor_angle (sangle_ff),
      .turn_angle   (tangle_ff),
      .edge_clamp   (clamp_ff),
      .rsp_data     (rsp_data)
   );

endmodule

### test/slime_agent_sense_turn_move_chk.sv
// Checker for the agent sense, turn and move block: tracks config and trail, predicts, compares.
module slime_agent_sense_turn_move_chk
   import sastm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  sastm_req_type         req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sastm_rsp_type         rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W_MAX = 512;
   localparam int H_MAX = 512;
   localparam int FRAC  = 8;

   logic [7:0] trail_mem [W_MAX*H_MAX];
   int grid_w, grid_h, step_len, probe_dist, probe_half, probe_ang, turn_ang, clamp_mode;
   sastm_rsp_type agent_moves_q [$];

   function automatic longint bound(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint round_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic int sin_q14(logic [15:0] h);
      longint r, x2, t;
      r = h[13:0];
      if (h[14]) r = 16384 - r;
      x2 = (r * r) >> 14;
      t = 10512 - ((1160 * x2) >> 14);
      t = 25736 - ((t * x2) >> 14);
      t = (t * r) >> 14;
      if (t > 16384) t = 16384;
      return h[15] ? -int'(t) : int'(t);
   endfunction

   function automatic int cos_q14(logic [15:0] h);
      return sin_q14(h + 16'd16384);
   endfunction

   function automatic longint fold(longint c, longint n);
      if (clamp_mode != 0) return bound(c, 0, n);
      if (c > n) return c - n;
      if (c < 0) return c + n;
      return c;
   endfunction

   function automatic int window_sum(longint x, longint y, logic [15:0] h, bit near,
                                     longint w, longint hg);
      longint half, cx, cy, px, py;
      int sum;
      half = probe_half > 2 ? 2 : probe_half;
      cx = round_sh(x * 16384 + longint'(cos_q14(h)) * probe_dist * 256, 14 + FRAC);
      cy = round_sh(y * 16384 + longint'(sin_q14(h)) * probe_dist * 256, 14 + FRAC);
      sum = 0;
      for (longint dx = -half; dx <= half; dx++) begin
         for (longint dy = -half; dy <= half; dy++) begin
            px = cx + dx;
            py = cy + dy;
            if (near) begin
               px = fold(px, w);
               py = fold(py, hg);
            end
            px = bound(px, 0, w - 1);
            py = bound(py, 0, hg - 1);
            sum += trail_mem[py * w + px];
         end
      end
      return sum;
   endfunction

   function automatic sastm_rsp_type agent_step(sastm_req_type r);
      sastm_rsp_type o;
      longint w, hg, x, y, reach, nx, ny, rt;
      logic [15:0] h;
      int fwd, lft, rgt;
      bit near, hit;
      w = bound(grid_w, 1, W_MAX);
      hg = bound(grid_h, 1, H_MAX);
      x = longint'(r.agent_x);
      y = longint'(r.agent_y);
      h = r.agent_heading;
      rt = longint'($signed(r.random_turn));
      reach = (longint'(probe_dist) + (probe_half > 2 ? 2 : probe_half)) * 256;
      near = x < reach || x + reach > (w - 1) * 256 || y < reach || y + reach > (hg - 1) * 256;
      fwd = window_sum(x, y, h, near, w, hg);
      lft = window_sum(x, y, h + 16'(probe_ang), near, w, hg);
      rgt = window_sum(x, y, h - 16'(probe_ang), near, w, hg);
      if (fwd >= lft && fwd >= rgt) begin
         // keep heading
      end else if (fwd < lft && fwd < rgt) begin
         h = h + 16'((rt * turn_ang) >>> 15);
      end else if (lft > rgt) begin
         h = h + 16'(turn_ang);
      end else if (lft < rgt) begin
         h = h - 16'(turn_ang);
      end
      nx = x + round_sh(longint'(step_len) * cos_q14(h) * 256, 22);
      ny = y + round_sh(longint'(step_len) * sin_q14(h) * 256, 22);
      hit = nx < 0 || nx > (w - 1) * 256 || ny < 0 || ny > (hg - 1) * 256;
      if (hit) begin
         if (clamp_mode != 0) h = r.random_heading;
         nx = fold(nx, w * 256);
         ny = fold(ny, hg * 256);
      end
      o.new_x = 18'(bound(nx, 0, w * 256));
      o.new_y = 18'(bound(ny, 0, hg * 256));
      o.new_heading = h;
      o.edge_hit = hit;
      return o;
   endfunction

   always @(posedge clock) begin
      sastm_rsp_type want;
      if (reset) begin
         grid_w = 512; grid_h = 512; step_len = 448; probe_dist = 9;
         probe_half = 1; probe_ang = 8192; turn_ang = 8192; clamp_mode = 0;
         agent_moves_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_GRID_WIDTH:   grid_w = csr_wdata[9:0];
               REG_GRID_HEIGHT:  grid_h = csr_wdata[9:0];
               REG_SPEED:        step_len = csr_wdata[9:0];
               REG_SENSOR_RANGE: probe_dist = csr_wdata[4:0];
               REG_SENSOR_SIZE:  probe_half = csr_wdata[1:0];
               REG_SENSOR_ANGLE: probe_ang = csr_wdata[15:0];
               REG_TURN_ANGLE:   turn_ang = csr_wdata[15:0];
               REG_EDGE_CLAMP:   clamp_mode = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.opcode == OP_WRITE)
               trail_mem[req_data.cell_index] = req_data.trail_value;
            else
               agent_moves_q = {agent_moves_q, agent_step(req_data)};
         end
         if (rsp_valid && rsp_ready) begin
            if (agent_moves_q.size() == 0) begin
               $display("%0t: unexpected word, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = agent_moves_q.pop_front();
               if (rsp_data.new_x !== want.new_x || rsp_data.new_y !== want.new_y ||
                   rsp_data.new_heading !== want.new_heading ||
                   rsp_data.edge_hit !== want.edge_hit) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp_data);
                  fail_count++;
               end
            end
         end
      end
      pending_count = agent_moves_q.size();
   end

endmodule

### test/slime_agent_sense_turn_move_tb.sv
// Testbench top: clock, reset, stimulus phases over several settings, and the verdict.
module slime_agent_sense_turn_move_tb;
   import sastm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   sastm_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   sastm_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int fail_count, pending_count;

   bit cell_known [512*512];
   int eff_w, eff_h;
   bit gaps_on = 1'b1;
   bit stall_on = 1'b1;
   bit long_hold = 1'b0;
   int quiet_cycles;

   slime_agent_sense_turn_move dut (.*);
   slime_agent_sense_turn_move_chk chk (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("slime_agent_sense_turn_move regression: fail");
         $finish;
      end
   end

   // receiver: random stalls, and one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (2000) @(posedge clock);
         end else if (stall_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(sastm_req_type r);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      if (r.opcode == OP_WRITE) cell_known[r.cell_index] = 1'b1;
   endtask

   function automatic sastm_req_type noise_word();
      sastm_req_type r;
      r.opcode = OP_WRITE;
      r.cell_index = 18'($urandom);
      r.trail_value = 8'($urandom);
      r.agent_x = 18'($urandom);
      r.agent_y = 18'($urandom);
      r.agent_heading = 16'($urandom);
      r.random_turn = 16'($urandom);
      r.random_heading = 16'($urandom);
      return r;
   endfunction

   task automatic put_cell(int idx, int val);
      sastm_req_type r;
      r = noise_word();
      r.cell_index = 18'(idx);
      r.trail_value = 8'(val);
      send_word(r);
   endtask

   task automatic move_agent(int x, int y, int h, int rt, int rh);
      sastm_req_type r;
      r = noise_word();
      r.opcode = OP_UPDATE;
      r.agent_x = 18'(x);
      r.agent_y = 18'(y);
      r.agent_heading = 16'(h);
      r.random_turn = 16'(rt);
      r.random_heading = 16'(rh);
      send_word(r);
   endtask

   task automatic drain();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (pending_count != 0) @(posedge clock);
      // a trailing write may still be in flight
      repeat (200) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
   endtask

   task automatic configure(int gw, int gh, int spd, int rng, int sz, int sa, int ta, int cl);
      drain();
      set_reg(REG_GRID_WIDTH, gw);
      set_reg(REG_GRID_HEIGHT, gh);
      set_reg(REG_SPEED, spd);
      set_reg(REG_SENSOR_RANGE, rng);
      set_reg(REG_SENSOR_SIZE, sz);
      set_reg(REG_SENSOR_ANGLE, sa);
      set_reg(REG_TURN_ANGLE, ta);
      set_reg(REG_EDGE_CLAMP, cl);
      csr_we <= 1'b0;
      @(posedge clock);
      eff_w = gw < 1 ? 1 : (gw > 512 ? 512 : gw);
      eff_h = gh < 1 ? 1 : (gh > 512 ? 512 : gh);
      // every cell a sensor can reach gets written before any update
      for (int i = 0; i < eff_w * eff_h; i++)
         if (!cell_known[i]) put_cell(i, $urandom_range(0, 255));
   endtask

   function automatic int pick_pos(int cells);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 262143);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 0 : cells * 256;
      return $urandom_range(0, cells * 256);
   endfunction

   task automatic random_words(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 7) == 0)
               put_cell($urandom_range(0, 262143), $urandom_range(0, 255));
            else
               put_cell($urandom_range(0, eff_w * eff_h - 1), $urandom_range(0, 255));
         end else begin
            move_agent(pick_pos(eff_w), pick_pos(eff_h), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(16, 12, 448, 9, 1, 8192, 8192, 0);
      put_cell(0, 255);
      put_cell(262143, 0);
      put_cell(5, 0);
      put_cell(100, 255);
      move_agent(0, 0, 0, -32768, 0);
      move_agent(262143, 262143, 65535, 32767, 65535);
      move_agent(131072, 131072, 32768, 0, 65535);
      move_agent(8 * 256, 6 * 256, 16384, -32768, 0);
      move_agent(8 * 256, 6 * 256, 49152, 32767, 65535);
      move_agent(15 * 256, 11 * 256, 8192, -1, 12345);
      move_agent(3 * 256 + 128, 9 * 256 + 255, 40000, 1, 54321);
      // flat trail: all sides tie, heading holds
      for (int i = 0; i < 16 * 12; i++) put_cell(i, 7);
      move_agent(8 * 256, 6 * 256, 1000, 20000, 0);
      move_agent(0, 0, 0, 0, 0);
      random_words(20);

      configure(16, 12, 1023, 30, 2, 32768, 32768, 1);
      long_hold = 1'b1;
      random_words(30);

      configure(1023, 1, 0, 1, 0, 0, 0, 1);
      random_words(20);

      configure(0, 1023, 300, 5, 3, 65535, 65535, 0);
      random_words(20);

      configure(8, 8, 1023, 3, 1, 4000, 12000, 0);
      random_words(20);

      configure(24, 20, 200, 12, 2, 20000, 3000, 1);
      gaps_on = 1'b0;
      stall_on = 1'b0;
      random_words(25);

      drain();
      if (fail_count == 0)
         $display("slime_agent_sense_turn_move regression: pass");
      else
         $display("slime_agent_sense_turn_move regression: fail");
      $finish;
   end

endmodule

### filelist.f
rtl/sastm_pkg.sv
rtl/sastm_dp.sv
rtl/sastm_ctrl.sv
rtl/slime_agent_sense_turn_move.sv
test/slime_agent_sense_turn_move_chk.sv
test/slime_agent_sense_turn_move_tb.sv
